[hw/rtl/cmcr_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// cmcr_pkg
// Shared types, codes and saturating helpers for the chord-method cubic root
// finder.
// ============================================================================
package cmcr_pkg;

    // Input transfer: isolating interval, signed fixed point
    typedef struct packed {
        logic signed [31:0] interval_low;
        logic signed [31:0] interval_high;
    } cmcr_in_t;

    // Termination status
    typedef enum logic [1:0] {
        OUT_CONVERGED = 2'd0,
        OUT_LIMIT     = 2'd1,
        OUT_ZERO_DEN  = 2'd2
    } outcome_t;

    // Result transfer
    typedef struct packed {
        logic signed [31:0] root_estimate;
        logic [30:0]        last_step;
        logic [9:0]         steps_taken;
        outcome_t           outcome;
    } cmcr_out_t;

    // Status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Register select (word index bit of paddr)
    localparam logic REG_TOLERANCE  = 1'b0;
    localparam logic REG_ITER_LIMIT = 1'b1;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // Saturating 64-bit subtract
    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a - b;
        if ((a[63] != b[63]) && (r[63] != a[63])) begin
            r = a[63] ? S64_MIN : S64_MAX;
        end
        return r;
    endfunction

    // Magnitude of a signed 64-bit value (MIN maps to 2^63)
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Apply sign to a magnitude, saturating to signed 64 bits
    function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
        logic signed [63:0] r;
        if (neg) begin
            r = m[63] ? S64_MIN : -$signed(m);
        end else begin
            r = m[63] ? S64_MAX : $signed(m);
        end
        return r;
    endfunction

endpackage

[hw/rtl/cmcr_mul.sv]
`timescale 1ns / 1ps
// ============================================================================
// cmcr_mul
// 64x64 unsigned multiplier built from one 32x32 multiplier, four partial
// products accumulated into a 128-bit product.
// ============================================================================
module cmcr_mul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [63:0]           op_a,
    input  logic [63:0]           op_b,
    output logic [127:0]          prod,
    output cmcr_pkg::unit_stat_t  stat
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [1:0]   prev_idx;
    logic [6:0]   prev_sh;

    // Half select for this cycle's partial product
    assign a_half   = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half   = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    // Weight of the partial product registered last cycle
    assign prev_idx = cnt_reg[1:0] - 2'd1;
    assign prev_sh  = ({6'd0, prev_idx[1]} + {6'd0, prev_idx[0]}) << 5;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= op_a;
                b_reg    <= op_b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg != 3'd4) begin
                    pp_reg <= a_half * b_half;
                end
                if (cnt_reg != 3'd0) begin
                    acc_reg <= acc_reg + ({64'd0, pp_reg} << prev_sh);
                end
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hw/rtl/cmcr_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// cmcr_div
// 128-by-64 restoring divider, one quotient bit per cycle, quotient
// saturated to all ones when it cannot fit in 64 bits.
// ============================================================================
module cmcr_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [63:0]           num_hi,
    input  logic [63:0]           num_lo,
    input  logic [63:0]           divisor,
    output logic [63:0]           quot,
    output cmcr_pkg::unit_stat_t  stat
);

    logic [63:0] r_reg;
    logic [63:0] lo_reg;
    logic [63:0] d_reg;
    logic [63:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [63:0] r_sh;
    logic        take;

    // One restoring step
    assign r_sh = {r_reg[62:0], lo_reg[63]};
    assign take = r_reg[63] || (r_sh >= d_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                d_reg  <= divisor;
                r_reg  <= num_hi;
                lo_reg <= num_lo;
                if (num_hi >= divisor) begin
                    // quotient overflows
                    q_reg    <= '1;
                    done_reg <= 1'b1;
                end else begin
                    q_reg    <= '0;
                    busy_reg <= 1'b1;
                    cnt_reg  <= 7'd64;
                end
            end else if (busy_reg) begin
                r_reg   <= take ? (r_sh - d_reg) : r_sh;
                lo_reg  <= {lo_reg[62:0], 1'b0};
                q_reg   <= {q_reg[62:0], take};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hw/rtl/chord_method_cubic_root_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// chord_method_cubic_root_top
// Chord (fixed-end false position) root finder for x^3 - x - 1 in signed
// fixed point, built on a shared multiplier and a serial divider.
// ============================================================================
//  channel  | ports                      | moves
//  ---------+----------------------------+-------------------------------
//  input    | s_valid s_ready s_data     | interval (low, high)
//  result   | m_valid m_ready m_data     | root, last step, count, outcome
//  config   | psel penable pwrite paddr  | tolerance @0x0, limit @0x4
//
//  Each chord step is a cubic evaluation (two multiplies), one multiply
//  and the serial divider, which dominates.
//  s_ready is high only while the sequencer is idle; one item at a time.
//  The result register holds a finished transfer while m_ready is low;
//  the next item may be accepted meanwhile.
//  Reset is synchronous, active low; tolerance resets to 7, limit to 100.
// ============================================================================
module chord_method_cubic_root_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cmcr_pkg::cmcr_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cmcr_pkg::cmcr_out_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_WAIT1, S_MUL2, S_WAIT2, S_SUB1, S_SUB2,
        S_DEN, S_PROD, S_QUOT, S_UPD, S_ERR, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        R_FA, R_FD, R_FX
    } ret_t;

    state_t                state_reg;
    ret_t                  ret_reg;
    cmcr_pkg::cmcr_in_t    in_reg;
    logic signed [31:0]    x_reg;
    logic signed [31:0]    moving_reg;
    logic signed [31:0]    fixed_reg;
    logic signed [63:0]    acc_reg;
    logic signed [63:0]    fd_reg;
    logic signed [63:0]    fx_reg;
    logic signed [63:0]    den_reg;
    logic signed [63:0]    q_reg;
    logic                  neg_reg;
    logic [9:0]            count_reg;
    logic [32:0]           err_reg;
    cmcr_pkg::outcome_t    outcome_reg;
    logic [30:0]           tol_reg;
    logic [9:0]            lim_reg;
    logic                  m_valid_reg;
    cmcr_pkg::cmcr_out_t   m_data_reg;

    logic                  mul_start_reg;
    logic [63:0]           mul_a_reg;
    logic [63:0]           mul_b_reg;
    logic                  div_start_reg;
    logic [63:0]           div_hi_reg;
    logic [63:0]           div_lo_reg;
    logic [63:0]           div_d_reg;

    logic [127:0]          mul_prod;
    cmcr_pkg::unit_stat_t  mul_stat;
    logic [63:0]           div_q;
    cmcr_pkg::unit_stat_t  div_stat;

    logic [127:0]          prod_sh;
    logic                  prod_ovf;
    logic [63:0]           fix_mag;
    logic signed [63:0]    x_ext;
    logic signed [63:0]    f_val;
    logic                  f_pos;
    logic                  f_neg;
    logic                  a_pos;
    logic                  a_neg;
    logic signed [63:0]    den_val;
    logic signed [32:0]    diff;
    logic [32:0]           diff_mag;
    logic signed [63:0]    upd_val;
    logic signed [31:0]    x1_val;
    logic signed [32:0]    step;
    logic [32:0]           step_mag;
    logic [9:0]            count_inc;
    logic [30:0]           err_sat;

    // ------------------------------------------------------------------
    // Arithmetic units
    // ------------------------------------------------------------------
    cmcr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .prod    (mul_prod),
        .stat    (mul_stat)
    );

    cmcr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num_hi  (div_hi_reg),
        .num_lo  (div_lo_reg),
        .divisor (div_d_reg),
        .quot    (div_q),
        .stat    (div_stat)
    );

    // Fixed-point rescale of the product, saturating magnitude
    assign prod_sh  = mul_prod >> FRAC_BITS;
    assign prod_ovf = |(mul_prod >> (64 + FRAC_BITS));
    assign fix_mag  = prod_ovf ? '1 : prod_sh[63:0];

    // Cubic tail and end selection
    assign x_ext = 64'(x_reg);
    assign f_val = cmcr_pkg::sat_sub64(acc_reg, ONE);
    assign f_pos = !f_val[63] && (f_val != 64'sd0);
    assign f_neg = f_val[63];
    assign a_pos = !in_reg.interval_low[31] && (in_reg.interval_low != 32'sd0);
    assign a_neg = in_reg.interval_low[31];

    // Chord step terms
    assign den_val  = cmcr_pkg::sat_sub64(fx_reg, fd_reg);
    assign diff     = 33'(moving_reg) - 33'(fixed_reg);
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign upd_val  = cmcr_pkg::sat_sub64(64'(moving_reg), q_reg);
    assign x1_val   = (upd_val != 64'($signed(upd_val[31:0]))) ?
                      (upd_val[63] ? 32'sh8000_0000 : 32'sh7fff_ffff) : upd_val[31:0];
    assign step     = 33'(x_reg) - 33'(moving_reg);
    assign step_mag = step[32] ? 33'(-step) : 33'(step);
    assign count_inc = count_reg + 10'd1;
    assign err_sat  = (err_reg[32:31] != 2'b00) ? '1 : err_reg[30:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        x_reg     <= s_data.interval_low;
                        ret_reg   <= R_FA;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    mul_start_reg <= 1'b1;
                    mul_a_reg     <= cmcr_pkg::mag64(x_ext);
                    mul_b_reg     <= cmcr_pkg::mag64(x_ext);
                    state_reg     <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (mul_stat.done) begin
                        acc_reg   <= cmcr_pkg::from_mag(fix_mag, 1'b0);
                        state_reg <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    mul_start_reg <= 1'b1;
                    mul_a_reg     <= cmcr_pkg::mag64(acc_reg);
                    mul_b_reg     <= cmcr_pkg::mag64(x_ext);
                    state_reg     <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (mul_stat.done) begin
                        acc_reg   <= cmcr_pkg::from_mag(fix_mag, x_reg[31]);
                        state_reg <= S_SUB1;
                    end
                end
                S_SUB1: begin
                    acc_reg   <= cmcr_pkg::sat_sub64(acc_reg, x_ext);
                    state_reg <= S_SUB2;
                end
                S_SUB2: begin
                    case (ret_reg)
                        R_FA: begin
                            // fixed end is a when f(a) and a share a nonzero sign
                            if ((f_pos && a_pos) || (f_neg && a_neg)) begin
                                fixed_reg  <= in_reg.interval_low;
                                moving_reg <= in_reg.interval_high;
                                x_reg      <= in_reg.interval_low;
                            end else begin
                                fixed_reg  <= in_reg.interval_high;
                                moving_reg <= in_reg.interval_low;
                                x_reg      <= in_reg.interval_high;
                            end
                            ret_reg   <= R_FD;
                            state_reg <= S_MUL1;
                        end
                        R_FD: begin
                            fd_reg      <= f_val;
                            count_reg   <= '0;
                            err_reg     <= '0;
                            outcome_reg <= cmcr_pkg::OUT_LIMIT;
                            x_reg       <= moving_reg;
                            ret_reg     <= R_FX;
                            state_reg   <= (lim_reg == 10'd0) ? S_DONE : S_MUL1;
                        end
                        default: begin
                            fx_reg    <= f_val;
                            state_reg <= S_DEN;
                        end
                    endcase
                end
                S_DEN: begin
                    if (den_val == 64'sd0) begin
                        outcome_reg <= cmcr_pkg::OUT_ZERO_DEN;
                        state_reg   <= S_DONE;
                    end else begin
                        den_reg       <= den_val;
                        neg_reg       <= (fx_reg[63] ^ diff[32]) ^ den_val[63];
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= cmcr_pkg::mag64(fx_reg);
                        mul_b_reg     <= {31'd0, diff_mag};
                        state_reg     <= S_PROD;
                    end
                end
                S_PROD: begin
                    if (mul_stat.done) begin
                        div_start_reg <= 1'b1;
                        div_hi_reg    <= mul_prod[127:64];
                        div_lo_reg    <= mul_prod[63:0];
                        div_d_reg     <= cmcr_pkg::mag64(den_reg);
                        state_reg     <= S_QUOT;
                    end
                end
                S_QUOT: begin
                    if (div_stat.done) begin
                        q_reg     <= cmcr_pkg::from_mag(div_q, neg_reg);
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    x_reg     <= x1_val;
                    state_reg <= S_ERR;
                end
                S_ERR: begin
                    // x_reg holds the new iterate, moving_reg the old one
                    err_reg    <= step_mag;
                    moving_reg <= x_reg;
                    count_reg  <= count_inc;
                    if (step_mag < {2'b00, tol_reg}) begin
                        outcome_reg <= cmcr_pkg::OUT_CONVERGED;
                        state_reg   <= S_DONE;
                    end else if (count_inc == lim_reg) begin
                        outcome_reg <= cmcr_pkg::OUT_LIMIT;
                        state_reg   <= S_DONE;
                    end else begin
                        ret_reg   <= R_FX;
                        state_reg <= S_MUL1;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.root_estimate <= moving_reg;
                        m_data_reg.last_step     <= err_sat;
                        m_data_reg.steps_taken   <= count_reg;
                        m_data_reg.outcome       <= outcome_reg;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 31'd7;
            lim_reg <= 10'd100;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == cmcr_pkg::REG_ITER_LIMIT) begin
                lim_reg <= pwdata[9:0];
            end else begin
                tol_reg <= pwdata[30:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cmcr_pkg::REG_TOLERANCE) ? {1'b0, tol_reg} : {22'd0, lim_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    a_mul_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> (state_reg == S_WAIT1 || state_reg == S_WAIT2 ||
                           state_reg == S_PROD))
        else $error("multiply result arrived in an unexpected state");

    a_count_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEN) |-> (count_reg < lim_reg))
        else $error("chord step beyond iteration limit");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_MUL1))
        else $error("accepted transfer did not start evaluation");

endmodule
